@@ src/teabc_pkg.sv @@
// Shared types, constants and the mix function for the TEA block cipher.
`timescale 1ns / 1ps

package teabc_pkg;

	localparam int          ROUND_COUNT_DEF = 16;
	localparam int          WORD_W          = 32;
	localparam int          KEY_WORDS       = 4;
	localparam int          KEY_INDEX_W     = 2;
	localparam logic [31:0] DELTA           = 32'h9e37_79b9;

	// Operation codes carried in tuser
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	// Key words, index 0 in the lowest slot
	typedef word_t [KEY_WORDS-1:0] key_t;

	// One block moving down the cell row
	typedef struct packed {
		logic  valid;
		logic  op;
		word_t y;
		word_t z;
	} lane_t;

	// Mix term of one half-round, modulo 2^32
	function automatic word_t mix(input word_t v, input word_t sum, input word_t ka,
		input word_t kb);
		mix = (v << 4) + (ka ^ v) + (sum ^ (v >> 5)) + kb;
	endfunction

endpackage

@@ src/teabc_cell.sv @@
// One half-round cell of the cipher row: registers the word pair after one mix update.
`timescale 1ns / 1ps

module teabc_cell #(
	parameter int ROUND_COUNT = teabc_pkg::ROUND_COUNT_DEF,
	parameter int ROUND       = 0,
	parameter int HALF        = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  teabc_pkg::key_t     key,
	input  teabc_pkg::lane_t    lane_in,
	output teabc_pkg::lane_t    lane_out
);
	import teabc_pkg::*;

	// Round sums for this position, worked out at elaboration
	localparam logic [63:0] ENC_PROD = 64'(DELTA) * 64'(ROUND + 1);
	localparam logic [63:0] DEC_PROD = 64'(DELTA) * 64'(ROUND_COUNT - ROUND);
	localparam word_t       SUM_ENC  = ENC_PROD[WORD_W-1:0];
	localparam word_t       SUM_DEC  = DEC_PROD[WORD_W-1:0];
	localparam logic        FIRST    = (HALF == 0);

	word_t  sum;
	logic   upd_y;
	word_t  term;
	word_t  y_nx;
	word_t  z_nx;
	logic   valid_s1;
	logic   op_s1;
	word_t  y_s1;
	word_t  z_s1;

	// Encrypt updates y in the first half, decrypt updates z first
	always_comb begin
		sum   = (lane_in.op == OP_DECRYPT) ? SUM_DEC : SUM_ENC;
		upd_y = FIRST ^ (lane_in.op == OP_DECRYPT);
		if (upd_y) begin
			term = mix(lane_in.z, sum, key[0], key[1]);
		end else begin
			term = mix(lane_in.y, sum, key[2], key[3]);
		end
		y_nx = lane_in.y;
		z_nx = lane_in.z;
		if (upd_y) begin
			y_nx = (lane_in.op == OP_DECRYPT) ? lane_in.y - term : lane_in.y + term;
		end else begin
			z_nx = (lane_in.op == OP_DECRYPT) ? lane_in.z - term : lane_in.z + term;
		end
	end

	// Advance the row in step with the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= lane_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1 <= lane_in.op;
			y_s1  <= y_nx;
			z_s1  <= z_nx;
		end
	end

	always_comb begin
		lane_out.valid = valid_s1;
		lane_out.op    = op_s1;
		lane_out.y     = y_s1;
		lane_out.z     = z_s1;
	end

endmodule

@@ src/teabc_skid.sv @@
// Output register with a spare slot that decouples the cell row from downstream stalls.
`timescale 1ns / 1ps

module teabc_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [63:0]         in_data,
	output logic                in_ready,
	output logic                out_valid,
	output logic [63:0]         out_data,
	input  logic                out_ready
);
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic        spare_valid_q;
	logic [63:0] spare_data_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = !spare_valid_q;

	// Drain the spare first, else take the incoming transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (spare_valid_q) begin
				out_valid_q   <= 1'b1;
				spare_valid_q <= 1'b0;
			end else begin
				out_valid_q   <= in_valid;
			end
		end else if (in_valid && !spare_valid_q) begin
			spare_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			out_data_q <= spare_valid_q ? spare_data_q : in_data;
		end else if (in_valid && !spare_valid_q) begin
			spare_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ src/tea_block_cipher_16_rounds.sv @@
// Top level of the pipelined TEA block cipher with key registers and stream ports.
`timescale 1ns / 1ps

// TEA block cipher, one 64-bit block per cycle while the spare slot is empty. Each block
// passes through a row of 2 * ROUND_COUNT half-round cells, one register each, followed
// by an output register with a spare slot; a new block is taken every cycle while the
// spare slot is empty. The row advances as one while the spare slot is empty, so
// s_tready drops once the spare slot fills after downstream holds off. tuser selects
// the operation (0 encrypt, 1 decrypt). The user must write key words on the cfg port
// only while no block is in flight; the block itself does not enforce this.
module tea_block_cipher_16_rounds #(
	parameter int ROUND_COUNT = teabc_pkg::ROUND_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [teabc_pkg::KEY_INDEX_W-1:0] cfg_index,
	input  logic [teabc_pkg::WORD_W-1:0]  cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,  // block_high [31:0], block_low [63:32]
	input  logic                          s_tuser,  // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [63:0]                   m_tdata   // result_high [31:0], result_low [63:32]
);
	import teabc_pkg::*;

	localparam int CELLS = 2 * ROUND_COUNT;

	key_t  key_q;
	lane_t lane [CELLS+1];
	logic  advance;

	// Hold the key words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wen) begin
			key_q[cfg_index] <= cfg_wdata;
		end
	end

	assign s_tready = advance;

	// Feed the head of the row
	always_comb begin
		lane[0].valid = s_tvalid;
		lane[0].op    = s_tuser;
		lane[0].y     = s_tdata[31:0];
		lane[0].z     = s_tdata[63:32];
	end

	// Row of half-round cells
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		teabc_cell #(
			.ROUND_COUNT (ROUND_COUNT),
			.ROUND       (i / 2),
			.HALF        (i % 2)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.key      (key_q),
			.lane_in  (lane[i]),
			.lane_out (lane[i+1])
		);
	end

	teabc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lane[CELLS].valid),
		.in_data   ({lane[CELLS].z, lane[CELLS].y}),
		.in_ready  (advance),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_ready (m_tready)
	);

	// A full spare slot means the output register is full too
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled while the output register is empty");

	// A stalled row keeps its last block
	a_row_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(lane[CELLS]))
		else $error("last cell changed while the row was stalled");

	// The spare slot drains only after an output transfer
	a_spare_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && !$past(s_tready) && $past(arst_n)) |-> $past(m_tvalid && m_tready))
		else $error("spare slot drained without an output transfer");

endmodule

@@ tb/tb_tea_block_cipher_16_rounds.sv @@
// Self-checking stream testbench for the pipelined TEA block cipher with key registers.
`timescale 1ns / 1ps

module tb_tea_block_cipher_16_rounds;

	import teabc_pkg::*;

	localparam int          ROUNDS        = 16;
	localparam logic [31:0] ROUND_STEP    = 32'h9e37_79b9;
	localparam int          LATENCY       = 2 * ROUNDS + 1;
	localparam int          STALL_LIMIT   = 4000;
	localparam int          LONG_HOLD     = 300;
	localparam int          RANDOM_PHASES = 7;
	localparam int          PHASE_ITEMS   = 236;

	typedef struct {
		word_t high;
		word_t low;
	} block_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wen;
	logic [KEY_INDEX_W-1:0] cfg_index;
	word_t                  cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [63:0]            s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [63:0]            m_tdata;

	// Predictor copy of the key registers and the blocks still owed by the engine
	word_t  key_words [KEY_WORDS];
	block_t expected_blocks [$];

	int mismatches;
	int encrypt_count;
	int decrypt_count;
	int key_settings;
	int hold_request;
	int hold_count;
	int stall_count;
	int quiet_cycles;
	bit tx_gaps;
	bit rx_gaps;

	tea_block_cipher_16_rounds #(
		.ROUND_COUNT(ROUNDS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mix term of one half-round, all sums wrap at 32 bits
	function automatic word_t round_term(input word_t v, input word_t sum, input word_t ka,
		input word_t kb);
		return (v << 4) + (ka ^ v) + (sum ^ (v >> 5)) + kb;
	endfunction

	// Encrypt or decrypt one block under the current key copy
	function automatic block_t tea_crypt(input logic op, input word_t high, input word_t low);
		block_t res;
		word_t  y;
		word_t  z;
		word_t  sum;
		y = high;
		z = low;
		if (op == OP_ENCRYPT) begin
			sum = '0;
			for (int r = 0; r < ROUNDS; r++) begin
				sum += ROUND_STEP;
				y += round_term(z, sum, key_words[0], key_words[1]);
				z += round_term(y, sum, key_words[2], key_words[3]);
			end
		end else begin
			sum = ROUND_STEP * word_t'(ROUNDS);
			for (int r = 0; r < ROUNDS; r++) begin
				z -= round_term(y, sum, key_words[2], key_words[3]);
				y -= round_term(z, sum, key_words[0], key_words[1]);
				sum -= ROUND_STEP;
			end
		end
		res.high = y;
		res.low  = z;
		return res;
	endfunction

	// Random word, weighted toward the all-zero and all-one extremes
	function automatic word_t random_word();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Offer one block, hold it until the transfer, then maybe leave a gap
	task automatic send_block(input logic op, input word_t high, input word_t low);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {low, high};
		do begin
			@(posedge clk);
		end while (!s_tready);
		expected_blocks.push_back(tea_crypt(op, high, low));
		if (op == OP_ENCRYPT) encrypt_count++;
		else decrypt_count++;
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every owed block has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_blocks.size() != 0) @(posedge clk);
	endtask

	task automatic write_key(input int idx, input word_t val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= KEY_INDEX_W'(idx);
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		key_words[idx] = val;
	endtask

	// Load a full key, only with the engine empty
	task automatic set_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
		drain_results();
		write_key(0, k0);
		write_key(1, k1);
		write_key(2, k2);
		write_key(3, k3);
		key_settings++;
	endtask

	// Encrypt a block, then decrypt the predicted ciphertext back
	task automatic send_round_trip(input word_t high, input word_t low);
		block_t cipher;
		cipher = tea_crypt(OP_ENCRYPT, high, low);
		send_block(OP_ENCRYPT, high, low);
		send_block(OP_DECRYPT, cipher.high, cipher.low);
	endtask

	task automatic test_reset_key();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		key_settings++;
		send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
		send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
		send_block(OP_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
		send_block(OP_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555);
		drain_results();
	endtask

	task automatic test_key_extremes();
		set_key('1, '1, '1, '1);
		send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
		send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
		set_key('0, '1, '0, '1);
		send_block(OP_ENCRYPT, 32'hffff_ffff, 32'h0000_0000);
		send_block(OP_DECRYPT, 32'h0000_0000, 32'hffff_ffff);
		drain_results();
	endtask

	// Decryption must undo encryption exactly
	task automatic test_round_trip();
		set_key($urandom, $urandom, $urandom, $urandom);
		send_round_trip(32'h0000_0000, 32'h0000_0000);
		send_round_trip(32'hffff_ffff, 32'hffff_ffff);
		send_round_trip($urandom, $urandom);
		send_round_trip($urandom, $urandom);
		drain_results();
	endtask

	// Hold the output off while blocks keep coming, so the row fills and stalls
	task automatic test_full_pipeline_stall();
		drain_results();
		tx_gaps      = 1'b0;
		hold_request = LONG_HOLD;
		for (int i = 0; i < 80; i++) begin
			send_block(logic'($urandom_range(0, 1)), random_word(), random_word());
		end
		drain_results();
	endtask

	// Short bursts, each followed by a full drain before the next
	task automatic test_drain_pauses();
		int burst;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		for (int b = 0; b < 6; b++) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst; i++) begin
				send_block(logic'($urandom_range(0, 1)), random_word(), random_word());
			end
			drain_results();
		end
	endtask

	task automatic test_random_traffic();
		int sent;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					set_key('1, '1, '1, '1);
				end
				1: begin
					set_key('0, '0, '0, '0);
				end
				2: begin
					set_key('0, '1, 32'h8000_0000, 32'h0000_0001);
				end
				default: begin
					set_key($urandom, $urandom, $urandom, $urandom);
				end
			endcase
			// Phase 3 and the final phase run with no idling at all
			tx_gaps = (p != 3) && (p != RANDOM_PHASES - 1);
			rx_gaps = tx_gaps;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0) begin
					send_round_trip(random_word(), random_word());
					sent += 2;
				end else begin
					send_block(logic'($urandom_range(0, 1)), random_word(), random_word());
					sent++;
				end
			end
		end
	endtask

	// Check each output transfer and drive the receiver's ready
	always @(posedge clk) begin
		block_t want;
		if (m_tvalid && m_tready) begin
			if (expected_blocks.size() == 0) begin
				report_mismatch("block with nothing pending", m_tdata[31:0], '0);
			end else begin
				want = expected_blocks.pop_front();
				if (m_tdata[31:0] !== want.high)
					report_mismatch("result_high", m_tdata[31:0], want.high);
				if (m_tdata[63:32] !== want.low)
					report_mismatch("result_low", m_tdata[63:32], want.low);
			end
		end
		if (hold_request > 0) begin
			hold_count   = hold_request;
			hold_request = 0;
		end
		if (hold_count > 0) begin
			hold_count--;
			m_tready <= 1'b0;
		end else if (stall_count > 0) begin
			stall_count--;
			m_tready <= 1'b0;
		end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
			stall_count = $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// End the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("tea_block_cipher_16_rounds verification failed");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tuser   <= OP_ENCRYPT;
		s_tdata   <= '0;
		m_tready  <= 1'b0;
		mismatches    = 0;
		encrypt_count = 0;
		decrypt_count = 0;
		key_settings  = 0;
		hold_request  = 0;
		hold_count    = 0;
		stall_count   = 0;
		quiet_cycles  = 0;
		tx_gaps       = 1'b0;
		rx_gaps       = 1'b0;
		foreach (key_words[i]) key_words[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_key_extremes();
		test_round_trip();
		test_full_pipeline_stall();
		test_drain_pauses();
		test_random_traffic();

		drain_results();
		repeat (LATENCY + 8) @(posedge clk);
		$display("run covered %0d encryptions and %0d decryptions under %0d keys",
			encrypt_count, decrypt_count, key_settings);
		$display("with round trips, a %0d-cycle output hold-off and drained pauses", LONG_HOLD);
		if (mismatches == 0 && expected_blocks.size() == 0) begin
			$display("tea_block_cipher_16_rounds verification clean");
		end else begin
			$display("tea_block_cipher_16_rounds verification failed");
		end
		$finish;
	end

endmodule
